// ===== hdl/text_run_collector_terminator_detect_top_macros.svh =====
// Assertion macros shared by the checker of the text run collector.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef TEXT_RUN_COLLECTOR_TERMINATOR_DETECT_TOP_MACROS_SVH
`define TEXT_RUN_COLLECTOR_TERMINATOR_DETECT_TOP_MACROS_SVH

// Property checked only outside reset.
`define RTCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, including those during and just after reset.
`define RTCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rtcd_pkg.sv =====
// ---------------------------------------------------------------------------
// rtcd_pkg
// Types and constants shared by the text run collector modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtcd_pkg;

  // Depth of the terminator window, in characters (1 to 8).
  localparam int MAX_TERM = 8;
  localparam int FILL_W   = $clog2(MAX_TERM + 1);
  // Width used to compare the fill count against the terminator length.
  localparam int CMP_W    = 5;

  localparam int RUN_W    = 17;
  localparam logic [RUN_W-1:0] RUN_TOP = {RUN_W{1'b1}};

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_FOUND   = 2'd1,
    ST_RUN_ERR = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_MAX_RUN    = 2'd0,
    REG_TERM_LEN   = 2'd1,
    REG_TERM_BYTES = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [15:0] max_run;
    logic [3:0]  term_len;
    logic [63:0] term_bytes;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] mapped_char;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/rtcd_cfg.sv =====
// ---------------------------------------------------------------------------
// rtcd_cfg
// Configuration registers of the text run collector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtcd_cfg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  output rtcd_pkg::cfg_t           cfg
);
  import rtcd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_run    <= 16'd16;
      cfg.term_len   <= 4'd1;
      cfg.term_bytes <= 64'd10;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_RUN:    cfg.max_run    <= cfg_data[15:0];
        REG_TERM_LEN:   cfg.term_len   <= cfg_data[3:0];
        REG_TERM_BYTES: cfg.term_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rtcd_collect.sv =====
// ---------------------------------------------------------------------------
// rtcd_collect
// Byte classification, non-text run counter, character window and match.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtcd_collect (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rtcd_pkg::cfg_t cfg,
  input  wire logic          step,
  input  wire logic          action,
  input  wire logic [7:0]    data_byte,
  output rtcd_pkg::result_t  res
);
  import rtcd_pkg::*;

  logic [RUN_W-1:0]  run, run_next, run_inc;
  logic [7:0]        win      [MAX_TERM];
  logic [7:0]        win_next [MAX_TERM];
  logic [FILL_W-1:0] fill, fill_next, fill_inc;
  logic              is_text;
  logic              match;
  logic [7:0]        mapped;

  always_comb begin
    is_text = ((data_byte >= CHAR_SPACE) && (data_byte <= CHAR_TILDE)) ||
              (data_byte == CHAR_CR) || (data_byte == CHAR_LF) ||
              (data_byte == CHAR_TAB);
    mapped   = is_text ? data_byte : CHAR_DOT;
    run_inc  = (run == RUN_TOP) ? run : run + 1'b1;
    fill_inc = (fill == FILL_W'(MAX_TERM)) ? fill : fill + 1'b1;
  end

  always_comb begin
    run_next  = run;
    fill_next = fill;
    win_next  = win;
    match     = 1'b0;
    res.status      = ST_ACCEPT;
    res.mapped_char = 8'd0;

    if (action_t'(action) == ACT_CLEAR) begin
      run_next  = '0;
      fill_next = '0;
      for (int i = 0; i < MAX_TERM; i++) begin
        win_next[i] = 8'd0;
      end
      res.status = ST_CLEARED;
    end else if (!is_text && ({1'b0, cfg.max_run} < run_inc)) begin
      // Rejected: the run count still advances, the window stays put.
      run_next   = run_inc;
      res.status = ST_RUN_ERR;
    end else begin
      run_next    = is_text ? '0 : run_inc;
      fill_next   = fill_inc;
      win_next[0] = mapped;
      for (int i = 1; i < MAX_TERM; i++) begin
        win_next[i] = win[i-1];
      end
      match = (CMP_W'(cfg.term_len) <= CMP_W'(MAX_TERM)) &&
              (CMP_W'(fill_next) >= CMP_W'(cfg.term_len));
      for (int i = 0; i < MAX_TERM; i++) begin
        if ((CMP_W'(i) < CMP_W'(cfg.term_len)) &&
            (win_next[i] != cfg.term_bytes[8*i +: 8])) begin
          match = 1'b0;
        end
      end
      res.status      = match ? ST_FOUND : ST_ACCEPT;
      res.mapped_char = mapped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= '0;
      fill <= '0;
      for (int i = 0; i < MAX_TERM; i++) begin
        win[i] <= 8'd0;
      end
    end else if (step) begin
      run  <= run_next;
      fill <= fill_next;
      win  <= win_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/text_run_collector_terminator_detect_top.sv =====
// ---------------------------------------------------------------------------
// text_run_collector_terminator_detect_top
// Byte stream text collector with non-text run limit and terminator detect.
// ---------------------------------------------------------------------------
// Each request on the slave side is either a data byte (tuser low) or a clear
// (tuser high), and produces exactly one result on the master side. A data
// byte is classified as text (0x20 to 0x7E, CR, LF or tab) and mapped to
// itself, otherwise to '.'. Consecutive non-text bytes are counted; one that
// takes the count above max_run is rejected with status 2 and not stored.
// Stored characters enter an eight-character window, and status 1 reports
// that the newest term_len characters equal the terminator held in
// term_bytes (low byte is the last character). A clear request resets the
// counter and the window and answers with status 3. The block takes one
// request every clock cycle while the master side does not stall. A
// request is held in the input register, where its result is formed, and
// the result is then loaded into the result register and offered on the
// master side. The run counter and window are updated as each byte moves
// on, before the next one. Backpressure on the master side stalls both
// registers; the input register still takes a new request while the result
// register is full but its own slot is empty.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should only change while no request is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_run_collector_terminator_detect_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave side: request stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] action
  // Master side: result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] mapped_char
  output logic [1:0]       m_tuser,   // [1:0] status
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import rtcd_pkg::*;

  cfg_t    cfg;
  result_t res;

  // Input register stage.
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;

  // The result register can load whenever it is empty or being drained.
  logic advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  rtcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Collector state advances exactly when the held request moves on.
  rtcd_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (in_valid && advance),
    .action    (in_action),
    .data_byte (in_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tuser <= res.status;
      m_tdata <= res.mapped_char;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rtcd_checker.sv =====
// ---------------------------------------------------------------------------
// rtcd_checker
// Port-level checks of the text run collector, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_run_collector_terminator_detect_top_macros.svh"

module rtcd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic [1:0]  m_tuser
);
  import rtcd_pkg::*;

  // A stalled result must hold still.
  `RTCD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // Rejected and cleared results carry no character.
  `RTCD_ASSERT(a_no_char, m_tvalid && (m_tuser == ST_RUN_ERR || m_tuser == ST_CLEARED) |-> m_tdata == 8'd0, "character on error or clear result")

  // An accepted character is always text or the substitute dot.
  `RTCD_ASSERT(a_text_char, m_tvalid && (m_tuser == ST_ACCEPT || m_tuser == ST_FOUND) |-> (m_tdata >= CHAR_SPACE && m_tdata <= CHAR_TILDE) || m_tdata == CHAR_CR || m_tdata == CHAR_LF || m_tdata == CHAR_TAB, "accepted character is not text")

  // Nothing is offered in the cycle after a reset edge.
  `RTCD_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind text_run_collector_terminator_detect_top rtcd_checker u_rtcd_checker (.*);

`default_nettype wire

// ===== tb/rtcd_result_monitor.sv =====
// ---------------------------------------------------------------------------
// rtcd_result_monitor
// Watches the request, result and configuration ports of the text run
// collector, predicts every result and compares it with the one delivered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtcd_result_monitor
  import rtcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               fail_count,
  output int               outstanding
);

  // Configuration as the block should currently see it.
  logic [15:0] run_limit;
  logic [3:0]  term_len;
  logic [63:0] term_bytes;

  // Collector state: run of non-text bytes, window (entry 0 newest), fill.
  logic [RUN_W-1:0] nontext_len;
  logic [7:0]       window [MAX_TERM];
  logic [3:0]       fill;

  result_t awaited_results [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t ns] %s", $time, msg);
  endtask

  function automatic bit is_text_char(input logic [7:0] b);
    return (b >= CHAR_SPACE && b <= CHAR_TILDE) || b == CHAR_CR || b == CHAR_LF ||
           b == CHAR_TAB;
  endfunction

  task automatic clear_collector();
    nontext_len = '0;
    fill = '0;
    for (int i = 0; i < MAX_TERM; i++) window[i] = 8'h00;
  endtask

  task automatic collect_byte(input action_t act, input logic [7:0] b, output result_t r);
    logic [7:0] ch;
    logic       hit;
    r.status = ST_ACCEPT;
    r.mapped_char = 8'h00;
    if (act == ACT_CLEAR) begin
      clear_collector();
      r.status = ST_CLEARED;
    end else begin
      if (is_text_char(b)) begin
        nontext_len = '0;
        ch = b;
      end else begin
        if (nontext_len != RUN_TOP) nontext_len++;
        ch = CHAR_DOT;
      end
      if (!is_text_char(b) && nontext_len > {1'b0, run_limit}) begin
        // Rejected: the run keeps growing, the window is left alone.
        r.status = ST_RUN_ERR;
      end else begin
        for (int i = MAX_TERM - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = ch;
        if (fill < MAX_TERM) fill++;
        hit = (term_len <= MAX_TERM) && (fill >= term_len);
        for (int i = 0; i < MAX_TERM; i++) begin
          if (i < term_len && window[i] != term_bytes[8*i +: 8]) hit = 1'b0;
        end
        r.status = hit ? ST_FOUND : ST_ACCEPT;
        r.mapped_char = ch;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      run_limit  = 16'd16;
      term_len   = 4'd1;
      term_bytes = 64'd10;
      clear_collector();
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      // Results leave only after their request has passed the input and result registers, so compare first.
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.mapped_char = m_tdata;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result status %0d char %02h with no request pending",
                                    got.status, got.mapped_char));
        end else begin
          want = awaited_results.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status mismatch: got %0d expected %0d",
                                      got.status, want.status));
          if (got.mapped_char != want.mapped_char)
            report_mismatch($sformatf("mapped char mismatch: got %02h expected %02h",
                                      got.mapped_char, want.mapped_char));
        end
      end
      if (s_tvalid && s_tready) begin
        collect_byte(action_t'(s_tuser), s_tdata, want);
        awaited_results.push_back(want);
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_MAX_RUN:    run_limit  = cfg_data[15:0];
          REG_TERM_LEN:   term_len   = cfg_data[3:0];
          REG_TERM_BYTES: term_bytes = cfg_data;
          default: ;
        endcase
      end
      outstanding <= awaited_results.size();
    end
  end

endmodule

// ===== tb/text_run_collector_terminator_detect_top_test.sv =====
// ---------------------------------------------------------------------------
// text_run_collector_terminator_detect_top_test
// Stream test of the text run collector with terminator detection.
// ---------------------------------------------------------------------------
// A short directed sequence covers the byte classes at their borders, the
// run limit error, terminator detection and clear. It is followed by random
// phases, each under its own configuration, where most requests replay the
// terminator or draw from its characters so that matches are frequent. The
// sender works in bursts with random gaps and the receiver stalls on its own
// pattern. The monitor predicts and compares every result; this module only
// makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_run_collector_terminator_detect_top_test;
  import rtcd_pkg::*;

  localparam int PHASE_REQUESTS = 175;
  localparam int NUM_PHASES     = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] mapped_char
  logic [1:0]  m_tuser;           // [1:0] status
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  int fail_count;
  int outstanding;

  // Stimulus bookkeeping: burst state and the configuration last written.
  int          burst_left = 0;
  int          requests_sent = 0;
  logic [15:0] cur_max_run = 16'd16;
  logic [3:0]  cur_term_len = 4'd1;
  logic [63:0] cur_term_bytes = 64'd10;

  text_run_collector_terminator_detect_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rtcd_result_monitor i_monitor (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: a stall mode is held for a random stretch, then another is
  // picked. Mode 0 never stalls, mode 3 holds long regular stalls.
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_tick % 12) >= 9;
    endcase
  end

  function automatic bit is_text_char(input logic [7:0] b);
    return (b >= CHAR_SPACE && b <= CHAR_TILDE) || b == CHAR_CR || b == CHAR_LF ||
           b == CHAR_TAB;
  endfunction

  function automatic logic [7:0] random_nontext();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (is_text_char(b));
    return b;
  endfunction

  function automatic logic [7:0] random_text();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       b = CHAR_CR;
      1:       b = CHAR_LF;
      2:       b = CHAR_TAB;
      default: b = $urandom_range(CHAR_SPACE, CHAR_TILDE);
    endcase
    return b;
  endfunction

  // Terminator character pool: a few letters, line endings, tab, the dot and
  // other text, plus an occasional arbitrary byte the block may never produce.
  function automatic logic [7:0] random_term_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'h61 + $urandom_range(0, 3);
      4:          b = CHAR_CR;
      5:          b = CHAR_LF;
      6:          b = CHAR_TAB;
      7:          b = CHAR_DOT;
      8:          b = $urandom_range(CHAR_SPACE, CHAR_TILDE);
      default:    b = $urandom_range(0, 255);
    endcase
    return b;
  endfunction

  // Presents one request and returns once it has been taken. Between bursts
  // the valid line may drop for a random gap.
  task automatic send_request(input action_t act, input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
      burst_left = $urandom_range(0, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops sending and waits until every predicted result has been delivered.
  // The opening wait lets the monitor count the last request taken.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] mr, input logic [3:0] tl,
                            input logic [63:0] tb);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_RUN;
    cfg_data  <= {48'd0, mr};
    @(posedge clk);
    cfg_index <= REG_TERM_LEN;
    cfg_data  <= {60'd0, tl};
    @(posedge clk);
    cfg_index <= REG_TERM_BYTES;
    cfg_data  <= tb;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_max_run    = mr;
    cur_term_len   = tl;
    cur_term_bytes = tb;
  endtask

  // Sends one terminator character. A dot may be produced either by the
  // dot itself or by any non-text byte.
  task automatic send_term_char(input int idx);
    logic [7:0] c;
    c = cur_term_bytes[8*idx +: 8];
    if (c == CHAR_DOT && $urandom_range(0, 1) == 1) send_request(ACT_DATA, random_nontext());
    else send_request(ACT_DATA, c);
  endtask

  task automatic run_random_phase();
    int         target;
    int         pick;
    int         len;
    target = requests_sent + PHASE_REQUESTS;
    len = (cur_term_len > MAX_TERM) ? MAX_TERM : cur_term_len;
    while (requests_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request(ACT_CLEAR, $urandom_range(0, 255));
      end else if (pick < 25) begin
        // Whole terminator, oldest character first.
        for (int i = len - 1; i >= 0; i--) send_term_char(i);
      end else if (pick < 35 && cur_max_run <= 20) begin
        // Non-text run just past the limit.
        repeat (cur_max_run + $urandom_range(1, 3)) send_request(ACT_DATA, random_nontext());
      end else if (pick < 65) begin
        send_term_char($urandom_range(0, MAX_TERM - 1));
      end else if (pick < 85) begin
        send_request(ACT_DATA, random_text());
      end else begin
        send_request(ACT_DATA, $urandom_range(0, 255));
      end
      // Now and then let the pipeline drain completely.
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  initial begin
    logic [63:0] word;
    logic [15:0] mr;
    logic [3:0]  tl;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: run limit 16, terminator LF.
    // Byte class borders on both sides.
    send_request(ACT_DATA, 8'h00);
    send_request(ACT_DATA, 8'hFF);
    send_request(ACT_DATA, CHAR_SPACE);
    send_request(ACT_DATA, CHAR_TILDE);
    send_request(ACT_DATA, 8'h1F);
    send_request(ACT_DATA, 8'h7F);
    send_request(ACT_DATA, CHAR_CR);
    send_request(ACT_DATA, CHAR_TAB);
    send_request(ACT_DATA, 8'h78);
    send_request(ACT_DATA, CHAR_LF);
    // After a clear the single-character terminator matches at once.
    send_request(ACT_CLEAR, 8'hA5);
    send_request(ACT_DATA, CHAR_LF);

    // Run limit of two and terminator "abc".
    set_config(16'd2, 4'd3, 64'h0000_0000_0061_6263);
    send_request(ACT_DATA, 8'h61);
    send_request(ACT_DATA, 8'h62);
    send_request(ACT_DATA, 8'h63);
    send_request(ACT_DATA, 8'h01);
    send_request(ACT_DATA, 8'h02);
    // Third and fourth non-text bytes exceed the limit and are rejected.
    send_request(ACT_DATA, 8'h03);
    send_request(ACT_DATA, 8'h04);
    send_request(ACT_DATA, 8'h5A);
    // Window not yet full enough after the clear.
    send_request(ACT_CLEAR, 8'h5A);
    send_request(ACT_DATA, 8'h62);
    send_request(ACT_DATA, 8'h63);

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < MAX_TERM; i++) word[8*i +: 8] = random_term_char();
      mr = $urandom_range(0, 12);
      tl = $urandom_range(1, MAX_TERM);
      case (p)
        0: begin
          // Zero limit and zero terminator length.
          mr = 16'd0;
          tl = 4'd0;
        end
        1: begin
          mr = 16'hFFFF;
          tl = 4'd8;
        end
        2: tl = 4'd15;
        3: tl = $urandom_range(MAX_TERM + 1, 14);
        4: word = '1;
        5: word = '0;
        6: word = {$urandom, $urandom};
        default: ;
      endcase
      set_config(mr, tl, word);
      run_random_phase();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("text_run_collector_terminator_detect_top_test: PASS");
    end else begin
      $display("text_run_collector_terminator_detect_top_test: FAIL");
    end
    $finish;
  end

  // Safety net far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("text_run_collector_terminator_detect_top_test: FAIL");
    $finish;
  end

endmodule
